FILE: hdl/mibt_pkg.sv
// Package with widths, payload structs and sequencer codes for the modular inverse block.
`timescale 1ns / 1ps
package mibt_pkg;

  localparam int unsigned DATA_WIDTH = 31;
  localparam int unsigned CNT_W      = $clog2(2 * DATA_WIDTH + 1);
  localparam int unsigned BIT_W      = $clog2(DATA_WIDTH);

  typedef struct packed {
    logic [DATA_WIDTH-1:0] value;
    logic [DATA_WIDTH-1:0] modulus;
  } in_t;

  typedef struct packed {
    logic [DATA_WIDTH-1:0] inverse;
    logic                  bad_modulus;
  } out_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_MUL
  } state_e;

  typedef enum logic [2:0] {
    OP_BMOD,
    OP_TD,
    OP_OUT,
    OP_PHI,
    OP_LAST,
    OP_SQ,
    OP_MB
  } op_e;

endpackage

FILE: hdl/modular_inverse_by_totient.sv
// Modular inverse by Euler's theorem: totient by trial division, then square-and-multiply.
// A zero modulus is answered in the cycle after the transfer; otherwise each trial divisor
// costs one or more passes of the shared shift-subtract divider, and the power stage costs
// up to 2*W modular multiplies, each a product reduced by that divider.
// A new item is taken only once the last one is done; busy_o stays high meanwhile.
// Reset (rst_ni low, asynchronous) returns the sequencer to idle and clears the result strobe.
`timescale 1ns / 1ps
module modular_inverse_by_totient (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  mibt_pkg::in_t    in_i,
  output logic             busy_o,
  output logic             valid_o,
  output mibt_pkg::out_t   result_o
);

  localparam int unsigned W = mibt_pkg::DATA_WIDTH;

  mibt_pkg::state_e state_q, state_d, post_state;
  mibt_pkg::op_e    op_q, op_d;

  logic [W-1:0]   m_q, m_d, rest_q, rest_d, p_q, p_d, phi_q, phi_d;
  logic [W-1:0]   acc_q, acc_d, b_q, b_d, exp_q, exp_d;
  logic [mibt_pkg::BIT_W-1:0] bit_q, bit_d;
  logic [2*W-1:0] prod_q, prod_d;

  logic [W-1:0]   rem_q, rem_d, d_q, d_d;
  logic [2*W-1:0] dq_q, dq_d;
  logic [mibt_pkg::CNT_W-1:0] cnt_q, cnt_d;

  logic           valid_q, valid_d;
  mibt_pkg::out_t res_q, res_d;

  logic           accept;
  logic [W:0]     trial;
  logic           ge;
  logic [W:0]     diff;
  logic [W-1:0]   quo, rmd, phi_new;

  assign accept  = start_i && (state_q == mibt_pkg::S_IDLE);
  assign trial   = {rem_q, dq_q[2*W-1]};
  assign ge      = trial >= {1'b0, d_q};
  assign diff    = trial - {1'b0, d_q};
  assign quo     = dq_q[W-1:0];
  assign rmd     = rem_q;
  assign phi_new = phi_q - quo;

  // Next state of the sequencer.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      mibt_pkg::S_IDLE: begin
        if (accept && (in_i.modulus != '0)) state_d = mibt_pkg::S_DIV;
      end
      mibt_pkg::S_DIV: begin
        if (cnt_q == '0) state_d = post_state;
      end
      mibt_pkg::S_MUL: state_d = mibt_pkg::S_DIV;
      default: state_d = mibt_pkg::S_IDLE;
    endcase
  end

  // Datapath and the decision taken when a division finishes.
  always_comb begin
    op_d = op_q; m_d = m_q; rest_d = rest_q; p_d = p_q; phi_d = phi_q;
    acc_d = acc_q; b_d = b_q; exp_d = exp_q; bit_d = bit_q; prod_d = prod_q;
    rem_d = rem_q; d_d = d_q; dq_d = dq_q; cnt_d = cnt_q;
    valid_d = 1'b0; res_d = res_q;
    post_state = mibt_pkg::S_DIV;

    unique case (state_q)
      mibt_pkg::S_IDLE: begin
        if (accept) begin
          if (in_i.modulus == '0) begin
            valid_d = 1'b1;
            res_d.inverse = '0;
            res_d.bad_modulus = 1'b1;
          end else begin
            m_d = in_i.modulus;
            op_d = mibt_pkg::OP_BMOD;
            rem_d = '0; d_d = in_i.modulus; dq_d = {in_i.value, {W{1'b0}}};
            cnt_d = mibt_pkg::CNT_W'(W);
          end
        end
      end
      mibt_pkg::S_MUL: begin
        // The registered product is loaded here; its reduction runs over the full double width.
        rem_d = '0; d_d = m_q; dq_d = prod_q;
        cnt_d = mibt_pkg::CNT_W'(2 * W);
      end
      mibt_pkg::S_DIV: begin
        if (cnt_q != '0) begin
          rem_d = ge ? diff[W-1:0] : trial[W-1:0];
          dq_d  = {dq_q[2*W-2:0], ge};
          cnt_d = cnt_q - 1'b1;
        end else begin
          // Short divisions load the dividend into the upper half of the shift register.
          rem_d = '0;
          cnt_d = mibt_pkg::CNT_W'(W);
          case (op_q) inside
            mibt_pkg::OP_BMOD: begin
              b_d = rmd; rest_d = m_q; phi_d = m_q; p_d = W'(2);
              op_d = mibt_pkg::OP_TD; d_d = W'(2); dq_d = {m_q, {W{1'b0}}};
            end
            mibt_pkg::OP_TD: begin
              if (p_q > quo) begin
                if (rest_q > W'(1)) begin
                  op_d = mibt_pkg::OP_LAST; d_d = rest_q; dq_d = {phi_q, {W{1'b0}}};
                end else begin
                  exp_d = phi_q - 1'b1;
                end
              end else if (rmd == '0) begin
                rest_d = quo; op_d = mibt_pkg::OP_OUT; d_d = p_q; dq_d = {quo, {W{1'b0}}};
              end else begin
                p_d = p_q + 1'b1; d_d = p_q + 1'b1; dq_d = {rest_q, {W{1'b0}}};
              end
            end
            mibt_pkg::OP_OUT: begin
              if (rmd == '0) begin
                rest_d = quo; d_d = p_q; dq_d = {quo, {W{1'b0}}};
              end else begin
                op_d = mibt_pkg::OP_PHI; d_d = p_q; dq_d = {phi_q, {W{1'b0}}};
              end
            end
            mibt_pkg::OP_PHI: begin
              phi_d = phi_new; p_d = p_q + 1'b1;
              op_d = mibt_pkg::OP_TD; d_d = p_q + 1'b1; dq_d = {rest_q, {W{1'b0}}};
            end
            mibt_pkg::OP_LAST: begin
              phi_d = phi_new; exp_d = phi_new - 1'b1;
            end
            mibt_pkg::OP_SQ, mibt_pkg::OP_MB: begin
              acc_d = rmd;
            end
            default: ;
          endcase

          // Entry into the power stage once the totient is known.
          if ((op_q == mibt_pkg::OP_LAST) ||
              ((op_q == mibt_pkg::OP_TD) && (p_q > quo) && (rest_q <= W'(1)))) begin
            acc_d = (m_q == W'(1)) ? '0 : W'(1);
            bit_d = mibt_pkg::BIT_W'(W - 1);
            op_d  = mibt_pkg::OP_SQ;
            prod_d = {{W{1'b0}}, acc_d} * {{W{1'b0}}, acc_d};
            post_state = mibt_pkg::S_MUL;
          end else if ((op_q == mibt_pkg::OP_SQ) && exp_q[bit_q]) begin
            op_d = mibt_pkg::OP_MB;
            prod_d = {{W{1'b0}}, rmd} * {{W{1'b0}}, b_q};
            post_state = mibt_pkg::S_MUL;
          end else if ((op_q == mibt_pkg::OP_SQ) || (op_q == mibt_pkg::OP_MB)) begin
            if (bit_q == '0) begin
              valid_d = 1'b1;
              res_d.inverse = rmd;
              res_d.bad_modulus = 1'b0;
              post_state = mibt_pkg::S_IDLE;
            end else begin
              bit_d = bit_q - 1'b1;
              op_d = mibt_pkg::OP_SQ;
              prod_d = {{W{1'b0}}, rmd} * {{W{1'b0}}, rmd};
              post_state = mibt_pkg::S_MUL;
            end
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mibt_pkg::S_IDLE;
      op_q    <= mibt_pkg::OP_BMOD;
      cnt_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
      cnt_q   <= cnt_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    m_q <= m_d; rest_q <= rest_d; p_q <= p_d; phi_q <= phi_d;
    acc_q <= acc_d; b_q <= b_d; exp_q <= exp_d; bit_q <= bit_d; prod_q <= prod_d;
    rem_q <= rem_d; d_q <= d_d; dq_q <= dq_d; res_q <= res_d;
  end

  assign busy_o   = (state_q != mibt_pkg::S_IDLE);
  assign valid_o  = valid_q;
  assign result_o = res_q;

`ifndef ASSERT_OFF
  a_strobe_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> !busy_o) else $error("result strobe while busy");
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && (in_i.modulus != '0)) |=> busy_o)
    else $error("accepted item did not start");
  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && result_o.bad_modulus) |-> (result_o.inverse == '0))
    else $error("bad modulus with nonzero result");
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == mibt_pkg::S_DIV) |-> (cnt_q <= mibt_pkg::CNT_W'(2 * W)))
    else $error("divider count out of range");
`endif

endmodule

FILE: bench/tb_modular_inverse_by_totient.sv
// Self-checking bench for the totient-based modular inverse: directed corners, then random items.
`timescale 1ns / 1ps
module tb_modular_inverse_by_totient;

  localparam int unsigned CYCLE_LIMIT = 40_000_000;
  localparam int unsigned DW = mibt_pkg::DATA_WIDTH;

  // Holds the results that the block should return, oldest first.
  class inverse_scoreboard;
    mibt_pkg::out_t pending_q[$];
    int   mismatches;
    int   checked;
    int   zero_mods;

    function longint unsigned euler_phi(longint unsigned m);
      longint unsigned rest;
      longint unsigned phi;
      longint unsigned p;
      rest = m;
      phi  = m;
      for (p = 2; p * p <= rest; p++) begin
        if (rest % p == 0) begin
          while (rest % p == 0) rest = rest / p;
          phi = phi - phi / p;
        end
      end
      if (rest > 1) phi = phi - phi / rest;
      return phi;
    endfunction

    function longint unsigned pow_mod(longint unsigned b, longint unsigned e,
                                      longint unsigned m);
      longint unsigned acc;
      acc = 1 % m;
      b   = b % m;
      for (int i = 63; i >= 0; i--) begin
        acc = (acc * acc) % m;
        if (e[i]) acc = (acc * b) % m;
      end
      return acc;
    endfunction

    function void note_input(mibt_pkg::in_t item);
      mibt_pkg::out_t want;
      longint unsigned m;
      m = item.modulus;
      if (m == 0) begin
        want.inverse     = '0;
        want.bad_modulus = 1'b1;
        zero_mods++;
      end else begin
        want.inverse     = DW'(pow_mod(item.value, euler_phi(m) - 1, m));
        want.bad_modulus = 1'b0;
      end
      pending_q = {pending_q, want};
    endfunction

    function void check_result(mibt_pkg::out_t got);
      mibt_pkg::out_t want;
      if (pending_q.size() == 0) begin
        $error("result with nothing pending: inverse=%0d bad_modulus=%0b",
               got.inverse, got.bad_modulus);
        mismatches++;
        return;
      end
      want = pending_q.pop_front();
      checked++;
      if (got.inverse !== want.inverse) begin
        $error("inverse: expected %0d, actual %0d", want.inverse, got.inverse);
        mismatches++;
      end
      if (got.bad_modulus !== want.bad_modulus) begin
        $error("bad_modulus: expected %0b, actual %0b", want.bad_modulus, got.bad_modulus);
        mismatches++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;
  logic start_i;
  mibt_pkg::in_t  in_i;
  logic busy_o;
  logic valid_o;
  mibt_pkg::out_t result_o;

  inverse_scoreboard sb = new();
  int unsigned cycles = 0;
  int          idle_pct;

  modular_inverse_by_totient u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .in_i    (in_i),
    .busy_o  (busy_o),
    .valid_o (valid_o),
    .result_o(result_o)
  );

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (rst_ni && valid_o) sb.check_result(result_o);
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // One transfer: wait out the random gap and busy, then raise start for one cycle.
  task automatic send_item(logic [DW-1:0] v, logic [DW-1:0] m);
    mibt_pkg::in_t item;
    item.value   = v;
    item.modulus = m;
    while ($urandom_range(99) < idle_pct) @(negedge clk_i);
    @(negedge clk_i);
    while (busy_o) @(negedge clk_i);
    start_i = 1'b1;
    in_i    = item;
    @(posedge clk_i);
    sb.note_input(item);
    @(negedge clk_i);
    start_i = 1'b0;
    in_i    = '0;
  endtask

  // Moduli are zero or kept cheap to factor: a small part shifted up, or a short random number.
  function automatic logic [DW-1:0] pick_modulus();
    logic [DW-1:0] m;
    case ($urandom_range(9))
      0:       m = '0;
      1, 2, 3: m = DW'($urandom_range(12'hfff, 1)) << $urandom_range(19);
      4:       m = DW'($urandom_range(12'hfff, 1)) << $urandom_range(30, 19);
      default: m = DW'($urandom_range(16'hffff, 1));
    endcase
    return m;
  endfunction

  initial begin
    logic [DW-1:0] all_ones;
    all_ones = '1;
    idle_pct = 21;
    start_i  = 1'b0;
    in_i     = '0;
    rst_ni   = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Zero modulus, modulus one, value zero, value above modulus and wide moduli.
    send_item(31'd5, 31'd0);
    send_item(all_ones, 31'd0);
    send_item(31'd7, 31'd1);
    send_item(31'd0, 31'd1);
    send_item(31'd0, 31'd13);
    send_item(31'd0, 31'd2);
    send_item(31'd3, 31'd7);
    send_item(31'd10, 31'd7);
    send_item(all_ones, 31'd97);
    send_item(31'd6, 31'd9);
    send_item(31'd7, 31'd12);
    send_item(31'd3, 31'd1024);
    send_item(all_ones, 31'h7ffffffe);
    send_item(31'd12345, 31'h7ffffffe);
    send_item(31'h2aaaaaaa, 31'h40000000);
    send_item(31'h55555555, 31'h40000000);
    send_item(all_ones, 31'd65521);
    send_item(31'd1, 31'd65535);

    for (int i = 0; i < 100; i++) begin
      if (i == 34) idle_pct = 59;
      if (i == 67) idle_pct = 0;
      send_item(DW'($urandom()), pick_modulus());
    end

    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    $display("checked %0d results, %0d with a zero modulus, in %0d cycles",
             sb.checked, sb.zero_mods, cycles);
    if (sb.mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

FILE: sim.f
hdl/mibt_pkg.sv
hdl/modular_inverse_by_totient.sv
bench/tb_modular_inverse_by_totient.sv
